[sv/hse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg
// Shared sizes, word types and controller/datapath command and status types
// for the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index 2*node+2 can reach 2*CAPACITY
    localparam int CHILD_W  = ADDR_W + 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     set_end;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     run_end;
        logic                     overflowed;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_BUILD_INIT,
        OP_BUILD_RD,
        OP_TAKE_V,
        OP_SIFT_CHK,
        OP_SIFT_L,
        OP_SIFT_R,
        OP_SIFT_MOVE,
        OP_EXTR_INIT,
        OP_EXTR_RD,
        OP_EXTR_V,
        OP_EXTR_WR,
        OP_OUT_INIT,
        OP_OUT_RD,
        OP_OUT_LD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_wait;
    } t_dp_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_le1;
        logic left_ge_lim;
        logic right_lt_lim;
        logic best_is_node;
        logic out_taken;
        logic out_last;
    } t_dp_status;

endpackage
`default_nettype wire

[sv/hse_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/hse_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_datapath
// Heap store, sift registers and output word register; executes one
// command from the controller per cycle.
// ----------------------------------------------------------------------------
module hse_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hse_pkg::t_dp_cmd   i_cmd,
    input  wire hse_pkg::t_in_word  i_in_word,
    input  wire logic               i_out_stall,
    output hse_pkg::t_dp_status     o_status,
    output logic                    o_out_valid,
    output hse_pkg::t_out_word      o_out_word
);

    logic [hse_pkg::CNT_W-1:0]           r_count;
    logic                                r_drop;
    logic                                r_out_valid;
    logic [hse_pkg::CNT_W-1:0]           r_k;
    logic [hse_pkg::CNT_W-1:0]           r_lim;
    logic [hse_pkg::ADDR_W-1:0]          r_node;
    logic [hse_pkg::ADDR_W-1:0]          r_idx;
    logic signed [hse_pkg::DATA_W-1:0]   r_v;
    logic signed [hse_pkg::DATA_W-1:0]   r_best_val;
    logic [hse_pkg::ADDR_W-1:0]          r_best_idx;
    hse_pkg::t_out_word                  r_out_word;

    logic                                ram_we;
    logic [hse_pkg::ADDR_W-1:0]          ram_waddr;
    logic [hse_pkg::DATA_W-1:0]          ram_wdata;
    logic [hse_pkg::ADDR_W-1:0]          ram_raddr;
    logic [hse_pkg::DATA_W-1:0]          ram_rdata;
    logic signed [hse_pkg::DATA_W-1:0]   rd_val;

    logic [hse_pkg::CHILD_W-1:0]         w_left;
    logic [hse_pkg::CHILD_W-1:0]         w_right;
    logic [hse_pkg::CHILD_W-1:0]         w_lim_ext;
    logic [hse_pkg::CNT_W-1:0]           w_k_m1;
    logic                                w_full;
    logic                                w_taken;
    logic                                w_last;

    assign rd_val    = $signed(ram_rdata);
    assign w_left    = hse_pkg::CHILD_W'({r_node, 1'b1});
    assign w_right   = w_left + hse_pkg::CHILD_W'(1);
    assign w_lim_ext = hse_pkg::CHILD_W'(r_lim);
    assign w_k_m1    = r_k - hse_pkg::CNT_W'(1);
    assign w_full    = (r_count == hse_pkg::CNT_W'(hse_pkg::CAPACITY));
    assign w_taken   = r_out_valid && !i_out_stall;
    assign w_last    = ((hse_pkg::CNT_W'(r_idx) + hse_pkg::CNT_W'(1)) == r_count);

    assign o_status.k_zero       = (r_k == '0);
    assign o_status.k_le1        = (r_k <= hse_pkg::CNT_W'(1));
    assign o_status.left_ge_lim  = (w_left >= w_lim_ext);
    assign o_status.right_lt_lim = (w_right < w_lim_ext);
    assign o_status.best_is_node = (r_best_idx == r_node);
    assign o_status.out_taken    = w_taken;
    assign o_status.out_last     = w_last;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // store port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_v;
        ram_raddr = r_node;
        case (i_cmd.op)
            hse_pkg::OP_LOAD: begin
                ram_we    = !w_full;
                ram_waddr = r_count[hse_pkg::ADDR_W-1:0];
                ram_wdata = i_in_word.value;
            end
            hse_pkg::OP_BUILD_RD: begin
                ram_raddr = w_k_m1[hse_pkg::ADDR_W-1:0];
            end
            hse_pkg::OP_SIFT_CHK: begin
                // no child left: drop the carried value into the hole
                if (o_status.left_ge_lim) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = w_left[hse_pkg::ADDR_W-1:0];
                end
            end
            hse_pkg::OP_SIFT_L: begin
                ram_raddr = w_right[hse_pkg::ADDR_W-1:0];
            end
            hse_pkg::OP_SIFT_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = o_status.best_is_node ? r_v : r_best_val;
            end
            hse_pkg::OP_EXTR_RD: begin
                ram_raddr = w_k_m1[hse_pkg::ADDR_W-1:0];
            end
            hse_pkg::OP_EXTR_V: begin
                ram_raddr = '0;
            end
            hse_pkg::OP_EXTR_WR: begin
                // old root goes to the freed tail slot
                ram_we    = 1'b1;
                ram_waddr = w_k_m1[hse_pkg::ADDR_W-1:0];
                ram_wdata = ram_rdata;
            end
            hse_pkg::OP_OUT_RD: begin
                ram_raddr = r_idx;
            end
            default: begin
            end
        endcase
    end

    hse_ram #(
        .WIDTH (hse_pkg::DATA_W),
        .DEPTH (hse_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // set bookkeeping and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == hse_pkg::OP_LOAD) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + hse_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.op == hse_pkg::OP_OUT_LD) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_wait && w_taken) begin
                r_out_valid <= 1'b0;
                if (w_last) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end
        end
    end

    // sift and readout working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            hse_pkg::OP_BUILD_INIT: begin
                r_k <= r_count >> 1;
            end
            hse_pkg::OP_BUILD_RD: begin
                r_node <= w_k_m1[hse_pkg::ADDR_W-1:0];
                r_lim  <= r_count;
                r_k    <= w_k_m1;
            end
            hse_pkg::OP_TAKE_V: begin
                r_v <= rd_val;
            end
            hse_pkg::OP_SIFT_L: begin
                if (rd_val > r_v) begin
                    r_best_val <= rd_val;
                    r_best_idx <= w_left[hse_pkg::ADDR_W-1:0];
                end else begin
                    r_best_val <= r_v;
                    r_best_idx <= r_node;
                end
            end
            hse_pkg::OP_SIFT_R: begin
                if (rd_val > r_best_val) begin
                    r_best_val <= rd_val;
                    r_best_idx <= w_right[hse_pkg::ADDR_W-1:0];
                end
            end
            hse_pkg::OP_SIFT_MOVE: begin
                r_node <= r_best_idx;
            end
            hse_pkg::OP_EXTR_INIT: begin
                r_k <= r_count;
            end
            hse_pkg::OP_EXTR_V: begin
                r_v <= rd_val;
            end
            hse_pkg::OP_EXTR_WR: begin
                r_lim  <= w_k_m1;
                r_node <= '0;
                r_k    <= w_k_m1;
            end
            hse_pkg::OP_OUT_INIT: begin
                r_idx <= '0;
            end
            hse_pkg::OP_OUT_LD: begin
                r_out_word.sorted_value <= rd_val;
                r_out_word.run_end      <= w_last;
                r_out_word.overflowed   <= r_drop;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_wait && w_taken && !w_last) begin
            r_idx <= r_idx + hse_pkg::ADDR_W'(1);
        end
    end

endmodule
`default_nettype wire

[sv/hse_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_controller
// Sequencer for load, heap build, extraction and readout phases.
// ----------------------------------------------------------------------------
module hse_controller (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_set_end,
    input  wire hse_pkg::t_dp_status i_status,
    output logic                     o_in_stall,
    output hse_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_INIT,
        S_BUILD_RD,
        S_BUILD_V,
        S_SIFT_CHK,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_MOVE,
        S_EXTR_INIT,
        S_EXTR_RD,
        S_EXTR_V,
        S_EXTR_WR,
        S_OUT_INIT,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_ret;
    logic   r_extr;
    logic   n_extr;

    // where a finished sift returns to
    assign w_ret      = r_extr ? S_EXTR_RD : S_BUILD_RD;
    assign o_in_stall = (r_state != S_LOAD);

    always_comb begin
        n_state           = r_state;
        n_extr            = r_extr;
        o_cmd.op          = hse_pkg::OP_IDLE;
        o_cmd.out_wait    = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.op = hse_pkg::OP_LOAD;
                    if (i_set_end) begin
                        n_state = S_BUILD_INIT;
                    end
                end
            end
            S_BUILD_INIT: begin
                o_cmd.op = hse_pkg::OP_BUILD_INIT;
                n_state  = S_BUILD_RD;
            end
            S_BUILD_RD: begin
                if (i_status.k_zero) begin
                    n_state = S_EXTR_INIT;
                end else begin
                    o_cmd.op = hse_pkg::OP_BUILD_RD;
                    n_state  = S_BUILD_V;
                end
            end
            S_BUILD_V: begin
                o_cmd.op = hse_pkg::OP_TAKE_V;
                n_extr   = 1'b0;
                n_state  = S_SIFT_CHK;
            end
            S_SIFT_CHK: begin
                o_cmd.op = hse_pkg::OP_SIFT_CHK;
                n_state  = i_status.left_ge_lim ? w_ret : S_SIFT_L;
            end
            S_SIFT_L: begin
                o_cmd.op = hse_pkg::OP_SIFT_L;
                n_state  = i_status.right_lt_lim ? S_SIFT_R : S_SIFT_MOVE;
            end
            S_SIFT_R: begin
                o_cmd.op = hse_pkg::OP_SIFT_R;
                n_state  = S_SIFT_MOVE;
            end
            S_SIFT_MOVE: begin
                o_cmd.op = hse_pkg::OP_SIFT_MOVE;
                n_state  = i_status.best_is_node ? w_ret : S_SIFT_CHK;
            end
            S_EXTR_INIT: begin
                o_cmd.op = hse_pkg::OP_EXTR_INIT;
                n_state  = S_EXTR_RD;
            end
            S_EXTR_RD: begin
                if (i_status.k_le1) begin
                    n_state = S_OUT_INIT;
                end else begin
                    o_cmd.op = hse_pkg::OP_EXTR_RD;
                    n_state  = S_EXTR_V;
                end
            end
            S_EXTR_V: begin
                o_cmd.op = hse_pkg::OP_EXTR_V;
                n_state  = S_EXTR_WR;
            end
            S_EXTR_WR: begin
                o_cmd.op = hse_pkg::OP_EXTR_WR;
                n_extr   = 1'b1;
                n_state  = S_SIFT_CHK;
            end
            S_OUT_INIT: begin
                o_cmd.op = hse_pkg::OP_OUT_INIT;
                n_state  = S_OUT_RD;
            end
            S_OUT_RD: begin
                o_cmd.op = hse_pkg::OP_OUT_RD;
                n_state  = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.op = hse_pkg::OP_OUT_LD;
                n_state  = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                o_cmd.out_wait = 1'b1;
                if (i_status.out_taken) begin
                    n_state = i_status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_extr  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_extr  <= n_extr;
        end
    end

endmodule
`default_nettype wire

[sv/heap_sort_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heap_sort_engine
// In-place heapsort of a set of signed 32-bit words, emitted ascending.
// ----------------------------------------------------------------------------
// Feed the words of a set one per cycle; the word with set_end high closes
// the set. Up to CAPACITY (16) words are kept in a single-port-read heap
// store; later words of the same set are discarded and every word of the
// resulting run carries overflowed. While a set is loading the input takes
// one word per cycle. After the closing word the input stalls until the
// last word of the sorted run has been taken. The sort uses one store read
// per cycle: a sift level steps through check, read left child, read right
// child (where one exists) and move. For a set of n words, building the
// heap takes n/2 sifts (rounded down) and extraction n-1 sifts, and readout
// steps through read, load and hold for each output word. Equal words come
// out in heapsort order, which is indistinguishable at the output.
// ----------------------------------------------------------------------------
module heap_sort_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire hse_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output hse_pkg::t_out_word       o_out_word
);

    hse_pkg::t_dp_cmd    cmd;
    hse_pkg::t_dp_status status;

    // sequencing: load, build, extract, readout
    hse_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_set_end  (i_in_word.set_end),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // heap store, sift registers and output word register
    hse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

[sv/hse_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_checker
// Port-level checks of the heap sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module hse_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire hse_pkg::t_in_word  i_in_word,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire hse_pkg::t_out_word o_out_word
);

    // no input word is taken while a run is being delivered
    a_stall_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while output word pending");

    // closing word of a set starts the sort
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.set_end) |=> o_in_stall)
        else $error("input not stalled after set end");

    // a run continues after a word that is not its last
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.run_end) |=> o_in_stall)
        else $error("input reopened in the middle of a run");

    // the last word of a run leaves the output empty
    a_run_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.run_end) |=> !o_out_valid)
        else $error("output word after run end");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heap_sort_engine. It feeds sets of signed words,
// predicts the ascending run that each closing word triggers (including the
// overflow flag for sets that exceed the store), and compares every output
// word in order. Both handshakes idle at random, with a long output hold-off
// and drains.
// ----------------------------------------------------------------------------
module testbench;

    // Stop offering fresh sets once this many words have been stored.
    localparam int ITEM_TARGET  = 470;
    // Worst case: every word closes a full set, with the longest random gaps on both sides.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam logic signed [hse_pkg::DATA_W-1:0] MOST_NEG =
        {1'b1, {(hse_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [hse_pkg::DATA_W-1:0] MOST_POS =
        {1'b0, {(hse_pkg::DATA_W-1){1'b1}}};

    // Value mixes for random sets.
    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_EDGES
    } t_value_mix;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    hse_pkg::t_in_word  i_in_word   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    hse_pkg::t_out_word o_out_word;

    // Shadow of the block's store for the set being loaded.
    logic signed [hse_pkg::DATA_W-1:0] held_words [hse_pkg::CAPACITY];
    int unsigned                       held_count   = 0;
    logic                              held_dropped = 1'b0;

    // Sorted words still owed by the block, oldest first.
    hse_pkg::t_out_word sorted_queue [$];

    int unsigned words_stored   = 0;
    int unsigned error_count    = 0;
    longint      cycle_count    = 0;
    bit          sender_idles   = 1'b0;
    bit          receiver_idles = 1'b0;
    bit          hold_request   = 1'b0;

    heap_sort_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Store the word (or drop it when the store is full); on the closing word
    // sort what is held ascending and queue one output word per element.
    function automatic void predict_word(input hse_pkg::t_in_word w);
        logic signed [hse_pkg::DATA_W-1:0] key;
        hse_pkg::t_out_word                r;
        int                                i;
        int                                j;
        if (held_count < hse_pkg::CAPACITY) begin
            held_words[held_count] = w.value;
            held_count++;
            words_stored++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!w.set_end) return;
        // Insertion sort on signed values; equal words are indistinguishable.
        for (i = 1; i < held_count; i++) begin
            key = held_words[i];
            j = i;
            while (j > 0 && held_words[j-1] > key) begin
                held_words[j] = held_words[j-1];
                j--;
            end
            held_words[j] = key;
        end
        for (i = 0; i < held_count; i++) begin
            r.sorted_value = held_words[i];
            r.run_end      = (i + 1 == held_count);
            r.overflowed   = held_dropped;
            sorted_queue.push_back(r);
        end
        // Start a fresh set.
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one word after an optional random gap; hold it until accepted.
    // Valid stays high on exit so back-to-back words need no extra edge.
    task automatic send_word(input logic signed [hse_pkg::DATA_W-1:0] value,
                             input logic last);
        hse_pkg::t_in_word w;
        int                gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.value    = value;
        w.set_end  = last;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(w);
    endtask

    // Drop valid and wait until every owed word has come out.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sorted_queue.size() != 0);
    endtask

    function automatic logic signed [hse_pkg::DATA_W-1:0] pick_value(
        input t_value_mix mix);
        case (mix)
            MIX_FULL:   return $urandom;
            MIX_NARROW: return int'($urandom_range(0, 16)) - 8;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return '0;
                    3:       return -1;
                    4:       return 1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int count, input t_value_mix mix);
        int i;
        for (i = 0; i < count; i++) begin
            send_word(pick_value(mix), i == count - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Stall the output: a long hold-off on request, otherwise a random wait
    // drawn after every word taken.
    initial begin : output_stall_gen
        int wait_cycles;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (i_rst_n && o_out_valid && !i_out_stall) begin
                wait_cycles = receiver_idles ? $urandom_range(0, 19) : 0;
                if (wait_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each word taken against the oldest owed word.
    always @(posedge i_clk) begin : result_monitor
        hse_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sorted_queue.size() == 0) begin
                $error("unexpected output word: sorted_value %0d run_end %b overflowed %b",
                       o_out_word.sorted_value, o_out_word.run_end, o_out_word.overflowed);
                error_count++;
            end else begin
                want = sorted_queue.pop_front();
                if (o_out_word.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, o_out_word.sorted_value);
                    error_count++;
                end
                if (o_out_word.run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end, o_out_word.run_end);
                    error_count++;
                end
                if (o_out_word.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %b, got %b",
                           want.overflowed, o_out_word.overflowed);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A set of one word: the closing word is also the only element.
    task automatic test_single_word();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_word(MOST_NEG, 1'b1);
    endtask

    // Both extremes, zero, minus one and repeats in one set.
    task automatic test_extremes_and_repeats();
        send_word(MOST_POS, 1'b0);
        send_word(MOST_NEG, 1'b0);
        send_word('0, 1'b0);
        send_word(-1, 1'b0);
        send_word(MOST_POS, 1'b0);
        send_word(MOST_NEG, 1'b1);
    endtask

    // Fill the store, then close with a word that must be dropped; the
    // largest value is used so that keeping it by mistake shows up.
    task automatic test_dropped_closing_word();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_set(hse_pkg::CAPACITY, MIX_FULL);
        // send_set closed the set; redo it with an open final word instead
        drain_outputs();
        repeat (hse_pkg::CAPACITY) send_word(pick_value(MIX_EDGES), 1'b0);
        send_word(MOST_POS, 1'b1);
    endtask

    // Hold the output off for a long stretch while two sets are offered
    // back to back, so the block holds the first run and stalls its input.
    task automatic test_output_holdoff();
        drain_outputs();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 1'b1;
        send_set(8, MIX_FULL);
        send_set(8, MIX_NARROW);
        drain_outputs();
    endtask

    // Random sets: mostly short, some up to capacity, a few overflowing.
    task automatic test_random_sets();
        int         pick;
        int         count;
        t_value_mix mix;
        while (words_stored < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      count = $urandom_range(1, 8);
            else if (pick < 90) count = $urandom_range(9, hse_pkg::CAPACITY);
            else count = $urandom_range(hse_pkg::CAPACITY + 1, hse_pkg::CAPACITY + 6);
            mix            = t_value_mix'($urandom_range(0, 2));
            // leave some sets without idling on either side
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            send_set(count, mix);
            if ($urandom_range(0, 7) == 0) drain_outputs();
        end
    endtask

    initial begin : main
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_word();
        test_extremes_and_repeats();
        test_dropped_closing_word();
        test_output_holdoff();
        test_random_sets();

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && sorted_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[heap_sort_engine.f]
sv/hse_pkg.sv
sv/hse_ram.sv
sv/hse_datapath.sv
sv/hse_controller.sv
sv/heap_sort_engine.sv
sv/hse_checker.sv
sim/testbench.sv
